// File: rtl/vefl_pkg.sv
// ----------------------------------------------------------------------------
// vefl_pkg
// Shared types and character constants of the vCard line filter.
// ----------------------------------------------------------------------------
package vefl_pkg;

	typedef logic [7:0] char_t;

	localparam char_t CH_NL    = 8'h0A;
	localparam char_t CH_CR    = 8'h0D;
	localparam char_t CH_SP    = 8'h20;
	localparam char_t CH_TAB   = 8'h09;
	localparam char_t CH_COLON = 8'h3A;
	localparam char_t CH_SEMI  = 8'h3B;
	localparam char_t CH_UPPER_N = 8'h4E;

	localparam int LEN_BEGIN   = 6;
	localparam int LEN_VERSION = 8;
	localparam int LEN_END     = 4;
	localparam int LEN_IMPP    = 5;

	localparam char_t PFX_BEGIN   [8] = '{"B", "E", "G", "I", "N", ":", 8'h00, 8'h00};
	localparam char_t PFX_VERSION [8] = '{"V", "E", "R", "S", "I", "O", "N", ":"};
	localparam char_t PFX_END     [8] = '{"E", "N", "D", ":", 8'h00, 8'h00, 8'h00, 8'h00};
	localparam char_t PFX_IMPP    [8] = '{"I", "M", "P", "P", ":", 8'h00, 8'h00, 8'h00};

	localparam logic [15:0] LIMIT_RESET = 16'd1024;

	localparam int TDATA_W = 24;
	localparam int TUSER_W = 3;

	// register byte addresses
	localparam logic [2:0] ADDR_OUTPUT_LIMIT = 3'h0;

	typedef struct packed {
		logic accept;
		logic start_read;
		logic emit_byte;
		logic emit_nl;
		logic emit_mark;
		logic clear_line;
	} vefl_cmd_t;

	typedef struct packed {
		logic in_ends;
		logic ovf;
		logic keep_fit;
		logic last;
		logic at_end;
		logic out_free;
	} vefl_sts_t;

	typedef enum logic [3:0] {
		ST_IN     = 4'b0001,
		ST_DECIDE = 4'b0010,
		ST_EMIT   = 4'b0100,
		ST_MARK   = 4'b1000
	} vefl_state_t;

	function automatic char_t fold_upper(input char_t c);
		if (c >= "a" && c <= "z")
			return c - 8'd32;
		return c;
	endfunction

endpackage

// File: rtl/vefl_ctrl.sv
// ----------------------------------------------------------------------------
// vefl_ctrl
// Line sequencer: collects bytes, decides at line end, then replays, marks or drops the line.
// ----------------------------------------------------------------------------
module vefl_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  vefl_pkg::vefl_sts_t sts,
	output vefl_pkg::vefl_cmd_t cmd
);
	import vefl_pkg::*;

	vefl_state_t state_q, state_d;

	assign s_tready = (state_q == ST_IN);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IN: begin
				cmd.accept = s_tvalid;
				if (s_tvalid && sts.in_ends)
					state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (sts.ovf) begin
					state_d = ST_MARK;
				end else if (sts.keep_fit) begin
					cmd.start_read = 1'b1;
					state_d        = ST_EMIT;
				end else if (sts.last) begin
					state_d = ST_MARK;
				end else begin
					cmd.clear_line = 1'b1;
					state_d        = ST_IN;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					if (!sts.at_end) begin
						cmd.emit_byte = 1'b1;
					end else begin
						cmd.emit_nl    = 1'b1;
						cmd.clear_line = 1'b1;
						state_d        = ST_IN;
					end
				end
			end
			ST_MARK: begin
				if (sts.out_free) begin
					cmd.emit_mark  = 1'b1;
					cmd.clear_line = 1'b1;
					state_d        = ST_IN;
				end
			end
			default: begin
				state_d = ST_IN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IN;
		else
			state_q <= state_d;
	end

endmodule

// File: rtl/vefl_dp.sv
// ----------------------------------------------------------------------------
// vefl_dp
// Line buffer, running line features, byte counter and output register.
// ----------------------------------------------------------------------------
module vefl_dp #(
	parameter int LINE_MAX = 63
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [7:0]                  s_tdata,   // [7:0] text_byte
	input  logic                        s_tlast,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [vefl_pkg::TDATA_W-1:0] m_tdata,  // [7:0] out_byte, [23:8] total_length
	output logic                        m_tlast,
	output logic [vefl_pkg::TUSER_W-1:0] m_tuser,  // [0] byte_valid, [1] end_of_text,
	                                               // [2] overlong_dropped
	input  logic [15:0]                 limit,
	input  vefl_pkg::vefl_cmd_t          cmd,
	output vefl_pkg::vefl_sts_t          sts
);
	import vefl_pkg::*;

	localparam int LEN_W = $clog2(LINE_MAX + 1);
	localparam int AW    = $clog2(LINE_MAX);

	char_t            mem [LINE_MAX];
	char_t            rdata_q;
	logic [LEN_W-1:0] len_q, ptr_q, rd_addr;
	logic             ovf_q, last_q;
	logic             m_begin_q, m_version_q, m_end_q, m_impp_q;
	logic             n0_q, n1_q;
	logic             colon_q, has_val_q, real_q, cr_q, sc_seen_q, sc_last_q;
	logic [15:0]      emitted_q;
	logic             m_tvalid_q;

	char_t            c, fc;
	logic             is_nl, store, nontrim, keep, fits, load;

	assign c       = s_tdata;
	assign fc      = fold_upper(s_tdata);
	assign is_nl   = (c == CH_NL);
	assign store   = cmd.accept && !is_nl && (len_q < LEN_W'(LINE_MAX));
	assign nontrim = !(c == CH_CR || c == CH_SP || c == CH_TAB || c == CH_NL);

	always_comb begin
		keep = (m_begin_q && len_q >= LEN_W'(LEN_BEGIN))
			|| (m_version_q && len_q >= LEN_W'(LEN_VERSION))
			|| (m_end_q && len_q >= LEN_W'(LEN_END))
			|| !colon_q
			|| (has_val_q && !(n0_q && n1_q && !real_q)
				&& !(m_impp_q && len_q >= LEN_W'(LEN_IMPP) && sc_last_q));
		fits = ({1'b0, emitted_q} + 17'(len_q) + 17'd1) <= {1'b0, limit};
	end

	assign load = cmd.emit_byte || cmd.emit_nl || cmd.emit_mark;

	assign sts.in_ends  = is_nl || s_tlast;
	assign sts.ovf      = ovf_q;
	assign sts.keep_fit = keep && fits;
	assign sts.last     = last_q;
	assign sts.at_end   = (ptr_q == len_q);
	assign sts.out_free = !m_tvalid_q || m_tready;

	always_comb begin
		if (cmd.start_read)
			rd_addr = '0;
		else if (cmd.emit_byte)
			rd_addr = ptr_q + LEN_W'(1);
		else
			rd_addr = ptr_q;
	end

	// line buffer
	always_ff @(posedge clk) begin
		if (store)
			mem[len_q[AW-1:0]] <= c;
		rdata_q <= mem[rd_addr[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			ptr_q       <= '0;
			ovf_q       <= 1'b0;
			last_q      <= 1'b0;
			m_begin_q   <= 1'b1;
			m_version_q <= 1'b1;
			m_end_q     <= 1'b1;
			m_impp_q    <= 1'b1;
			n0_q        <= 1'b0;
			n1_q        <= 1'b0;
			colon_q     <= 1'b0;
			has_val_q   <= 1'b0;
			real_q      <= 1'b0;
			cr_q        <= 1'b0;
			sc_seen_q   <= 1'b0;
			sc_last_q   <= 1'b0;
			emitted_q   <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			ptr_q <= rd_addr;
			if (cmd.accept) begin
				last_q <= s_tlast;
				if (!is_nl && !store)
					ovf_q <= 1'b1;
			end
			if (store) begin
				len_q <= len_q + LEN_W'(1);
				if (len_q < LEN_W'(LEN_BEGIN) && fc != PFX_BEGIN[len_q[2:0]])
					m_begin_q <= 1'b0;
				if (len_q < LEN_W'(LEN_VERSION) && fc != PFX_VERSION[len_q[2:0]])
					m_version_q <= 1'b0;
				if (len_q < LEN_W'(LEN_END) && fc != PFX_END[len_q[2:0]])
					m_end_q <= 1'b0;
				if (len_q < LEN_W'(LEN_IMPP) && fc != PFX_IMPP[len_q[2:0]])
					m_impp_q <= 1'b0;
				if (len_q == LEN_W'(0))
					n0_q <= (c == CH_UPPER_N);
				if (len_q == LEN_W'(1))
					n1_q <= (c == CH_COLON || c == CH_SEMI);
				if (!colon_q) begin
					if (c == CH_COLON)
						colon_q <= 1'b1;
				end else begin
					if (nontrim)
						has_val_q <= 1'b1;
					if (!(c == CH_SEMI || c == CH_SP || c == CH_TAB || c == CH_CR)
						|| (nontrim && cr_q))
						real_q <= 1'b1;
					if (c == CH_CR)
						cr_q <= 1'b1;
					if (nontrim) begin
						if (c == CH_COLON && !sc_seen_q) begin
							sc_seen_q <= 1'b1;
							sc_last_q <= 1'b1;
						end else begin
							sc_last_q <= 1'b0;
						end
					end
				end
			end
			if (cmd.clear_line && last_q)
				emitted_q <= '0;
			else if (cmd.emit_byte || cmd.emit_nl)
				emitted_q <= emitted_q + 16'd1;
			if (cmd.clear_line) begin
				len_q       <= '0;
				ovf_q       <= 1'b0;
				last_q      <= 1'b0;
				m_begin_q   <= 1'b1;
				m_version_q <= 1'b1;
				m_end_q     <= 1'b1;
				m_impp_q    <= 1'b1;
				n0_q        <= 1'b0;
				n1_q        <= 1'b0;
				colon_q     <= 1'b0;
				has_val_q   <= 1'b0;
				real_q      <= 1'b0;
				cr_q        <= 1'b0;
				sc_seen_q   <= 1'b0;
				sc_last_q   <= 1'b0;
			end
			if (load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (load) begin
			if (cmd.emit_byte) begin
				m_tdata <= {emitted_q + 16'd1, rdata_q};
				m_tuser <= 3'b001;
				m_tlast <= 1'b0;
			end else if (cmd.emit_nl) begin
				m_tdata <= {emitted_q + 16'd1, CH_NL};
				m_tuser <= {1'b0, last_q, 1'b1};
				m_tlast <= 1'b1;
			end else begin
				m_tdata <= {emitted_q, 8'h00};
				m_tuser <= {ovf_q, last_q, 1'b0};
				m_tlast <= 1'b1;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule

// File: rtl/vcard_empty_field_line_filter.sv
// ----------------------------------------------------------------------------
// vcard_empty_field_line_filter
// Drops empty-value, overlong and over-limit vCard lines; replays the rest.
// ----------------------------------------------------------------------------
// Input: one byte per cycle while a line is collected.
// At a line end a decision state follows; a kept line of L bytes is replayed
// (one buffer read per byte) with a newline item, or a marker item is sent.
// Output items leave through a register; a stalled output holds the replay.
// Reset clears control state and counters and sets the limit to 1024; the line buffer
// is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module vcard_empty_field_line_filter #(
	parameter int LINE_MAX = 63
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,   // [7:0] text_byte
	input  logic                         s_tlast,   // is_last
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [vefl_pkg::TDATA_W-1:0] m_tdata,   // [7:0] out_byte, [23:8] total_length
	output logic                         m_tlast,   // run_last
	output logic [vefl_pkg::TUSER_W-1:0] m_tuser,   // [0] byte_valid, [1] end_of_text,
	                                                // [2] overlong_dropped
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import vefl_pkg::*;

	logic [15:0] limit_q;
	vefl_cmd_t   cmd;
	vefl_sts_t   sts;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_OUTPUT_LIMIT) ? {16'h0000, limit_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			limit_q <= LIMIT_RESET;
		else if (psel && penable && pwrite && pready && paddr == ADDR_OUTPUT_LIMIT)
			limit_q <= pwdata[15:0];
	end

	vefl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	vefl_dp #(
		.LINE_MAX (LINE_MAX)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.limit    (limit_q),
		.cmd      (cmd),
		.sts      (sts)
	);

	// overlong marker carries no byte and closes the run
	a_ovf_marker: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> !m_tuser[0] && m_tlast)
		else $error("overlong marker malformed");

	// end of text always closes the run
	a_eot_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast)
		else $error("end of text without run end");

	// marker items carry a zero byte
	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == 8'h00)
		else $error("marker with nonzero byte");

	// a line end stops intake in the decision state
	a_line_end_stall: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tlast || s_tdata == CH_NL) |=> !s_tready)
		else $error("input taken during line decision");

endmodule
